[hdl/pcm_downmix_linear_resampler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the downmix resampler
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCM_DOWNMIX_LINEAR_RESAMPLER_UNIT_ASSERT_SVH
`define PCM_DOWNMIX_LINEAR_RESAMPLER_UNIT_ASSERT_SVH

// A condition that holds at every edge out of reset
`define PDLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A cause at one edge and its effect at the next
`define PDLR_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cause |=> effect) else $error(msg);

`endif

[hdl/pdlr_pkg.sv]
// ----------------------------------------------------------------------------
// pdlr_pkg
// Shared types and constants of the downmix resampler.
// ----------------------------------------------------------------------------
package pdlr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = 24;
  localparam int STEP_W          = 24;
  localparam int CHAN_CFG_W      = 4;
  localparam int RAW_W           = 32;
  localparam int REG_IDX_W       = 2;
  localparam int MAX_RESULTS     = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1 << PHASE_FRAC_BITS);
  localparam logic [STEP_W-1:0]  STEP_MIN  =
    STEP_W'(((1 << PHASE_FRAC_BITS) + MAX_RESULTS - 1) / MAX_RESULTS);

  typedef enum logic [1:0] {
    FMT_INT16   = 2'd0,
    FMT_INT24   = 2'd1,
    FMT_INT32   = 2'd2,
    FMT_FLOAT32 = 2'd3
  } fmt_t;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP    = 2'd2;

  typedef struct packed {
    fmt_t                    sample_format;
    logic [CHAN_CFG_W-1:0]   channel_count;
    logic [STEP_W-1:0]       phase_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_format: FMT_FLOAT32,
    channel_count: CHAN_CFG_W'(2),
    phase_step:    STEP_W'(196608)
  };

endpackage

[hdl/pcm_downmix_linear_resampler_unit.sv]
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler_unit
// Mono downmix of device frames with linear-interpolation rate conversion.
// ----------------------------------------------------------------------------
//  port group | direction | carries
//  -----------+-----------+----------------------------------------------
//  cfg_       | in        | register write: index, data
//  in_        | in        | one raw channel sample per request
//  out_       | out       | interpolated mono sample, last-of-run flag
//
//  The front takes one sample per cycle while the two-entry frame queue has room.
//  Per closed frame the back runs the serial divider, then steps through ST_MUL
//  and ST_OUT for each output; it takes no new frame until the run is done.
//  An output stall holds the back; the front keeps taking samples until the
//  queue fills. Reset is synchronous and clears history and phase.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pdlr_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [pdlr_pkg::STEP_W-1:0]             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pdlr_pkg::RAW_W-1:0]              in_raw_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pdlr_pkg::SAMPLE_BITS-1:0] out_mono_sample,
  output logic                                    out_last_of_run
);

  localparam int ENTRY_W = pdlr_pkg::SAMPLE_BITS + $clog2(MAX_CHANNELS)
                         + $clog2(MAX_CHANNELS + 1) + pdlr_pkg::STEP_W;

  pdlr_pkg::cfg_t     cfg_r;
  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pdlr_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdlr_pkg::REG_SAMPLE_FORMAT: cfg_r.sample_format <= pdlr_pkg::fmt_t'(cfg_data[1:0]);
        pdlr_pkg::REG_CHANNEL_COUNT:
          cfg_r.channel_count <= cfg_data[pdlr_pkg::CHAN_CFG_W-1:0];
        pdlr_pkg::REG_PHASE_STEP:    cfg_r.phase_step <= cfg_data;
        default: ;
      endcase
    end
  end

  pdlr_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_sample (in_raw_sample),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  pdlr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (pdlr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pdlr_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mono_sample (out_mono_sample),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[hdl/pdlr_queue.sv]
// ----------------------------------------------------------------------------
// pdlr_queue
// Short queue of closed frames between the front and back ends.
// ----------------------------------------------------------------------------
`include "pcm_downmix_linear_resampler_unit_assert.svh"

module pdlr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `PDLR_ASSERT(a_fill_bound, (cnt_r <= CNT_W'(DEPTH)), "queue fill count above depth")
  `PDLR_ASSERT_NEXT(a_fill_up, (push_fire && !pop_fire), (cnt_r == $past(cnt_r) + 1'b1), "queue fill count missed a push")

endmodule

[hdl/pdlr_front.sv]
// ----------------------------------------------------------------------------
// pdlr_front
// Converts raw channel samples to Q1.23 and sums the channels of a frame.
// ----------------------------------------------------------------------------
module pdlr_front #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdlr_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdlr_pkg::RAW_W-1:0]    in_raw_sample,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [pdlr_pkg::SAMPLE_BITS + $clog2(MAX_CHANNELS) + $clog2(MAX_CHANNELS + 1)
                + pdlr_pkg::STEP_W - 1:0] push_data
);

  localparam int SB     = pdlr_pkg::SAMPLE_BITS;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = SB + $clog2(MAX_CHANNELS);
  localparam int STEP_W = pdlr_pkg::STEP_W;
  localparam int MAN_W  = 24;
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic signed [SB-1:0] FIX_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] FIX_MIN = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] to_fixed(input pdlr_pkg::fmt_t fmt,
                                                   input logic [pdlr_pkg::RAW_W-1:0] raw);
    logic [7:0]              fexp;
    logic [7:0]              fsh;
    logic [MAN_W-1:0]        fman;
    logic [MAN_W-1:0]        fmag;
    logic signed [SB-1:0]    res;
    fexp = raw[30:23];
    fman = {(fexp != 8'd0), raw[22:0]};
    fsh  = EXP_BIAS - fexp;
    fmag = (fsh >= 8'(MAN_W)) ? '0 : (fman >> fsh[4:0]);
    unique case (fmt)
      pdlr_pkg::FMT_INT16: res = {raw[15:0], 8'h00};
      pdlr_pkg::FMT_INT24: res = raw[23:0];
      pdlr_pkg::FMT_INT32: res = raw[31:8];
      pdlr_pkg::FMT_FLOAT32: begin
        if (fexp == EXP_SPECIAL && raw[22:0] != 23'd0) begin
          res = '0;
        end else if (fexp >= EXP_BIAS) begin
          res = raw[31] ? FIX_MIN : FIX_MAX;
        end else begin
          res = raw[31] ? (~fmag + 1'b1) : fmag;
        end
      end
    endcase
    return res;
  endfunction

  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        idx_r;
  logic signed [SB-1:0]    sample_c;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0]        idx_nxt;
  logic [CNT_W-1:0]        cnt_eff;
  logic [STEP_W-1:0]       step_eff;
  logic                    accept;
  logic                    frame_done;

  assign sample_c = to_fixed(cfg.sample_format, in_raw_sample);
  assign sum_nxt  = sum_r + SUM_W'(sample_c);
  assign idx_nxt  = idx_r + 1'b1;

  // zero channels means one; clamp to what the sum is sized for
  assign cnt_eff  = (cfg.channel_count == '0) ? CNT_W'(1) :
                    (cfg.channel_count > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) :
                    CNT_W'(cfg.channel_count);
  // raise a tiny step so that a frame yields a bounded run of outputs
  assign step_eff = (cfg.phase_step < pdlr_pkg::STEP_MIN) ? pdlr_pkg::STEP_MIN :
                    cfg.phase_step;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign frame_done = (idx_nxt >= cnt_eff);
  assign push_valid = accept && frame_done;
  assign push_data  = {sum_nxt, cnt_eff, step_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (accept) begin
      if (frame_done) begin
        sum_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

endmodule

[hdl/pdlr_back.sv]
// ----------------------------------------------------------------------------
// pdlr_back
// Averages a closed frame and emits its run of interpolated outputs, which may be empty.
// ----------------------------------------------------------------------------
`include "pcm_downmix_linear_resampler_unit_assert.svh"

module pdlr_back #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  logic [pdlr_pkg::SAMPLE_BITS + $clog2(MAX_CHANNELS) + $clog2(MAX_CHANNELS + 1)
                + pdlr_pkg::STEP_W - 1:0]      pop_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pdlr_pkg::SAMPLE_BITS-1:0] out_mono_sample,
  output logic                                 out_last_of_run
);

  localparam int SB      = pdlr_pkg::SAMPLE_BITS;
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W   = SB + $clog2(MAX_CHANNELS);
  localparam int STEP_W  = pdlr_pkg::STEP_W;
  localparam int PH_W    = pdlr_pkg::PHASE_W;
  localparam int FRAC    = pdlr_pkg::PHASE_FRAC_BITS;
  localparam int BIT_W   = $clog2(SUM_W);
  localparam int NRES_W  = $clog2(pdlr_pkg::MAX_RESULTS);
  localparam int PROD_W  = SUM_W + FRAC + 2;
  localparam logic [PH_W:0] ONE_X = (PH_W+1)'(1 << FRAC);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t                   state_r;
  logic [SUM_W-1:0]         dvd_r;
  logic [CNT_W-1:0]         rem_r;
  logic [CNT_W-1:0]         dvs_r;
  logic                     neg_r;
  logic [BIT_W-1:0]         bit_cnt_r;
  logic [STEP_W-1:0]        step_r;
  logic [SUM_W-1:0]         mono_r;
  logic [SUM_W-1:0]         prev_r;
  logic                     have_prev_r;
  logic [PH_W-1:0]          phase_r;
  logic [NRES_W-1:0]        nres_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SB-1:0]            out_mono_r;
  logic                     out_last_r;
  logic                     out_valid_r;

  logic signed [SUM_W-1:0]  e_sum;
  logic [CNT_W-1:0]         e_cnt;
  logic [STEP_W-1:0]        e_step;
  logic [SUM_W-1:0]         e_mag;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           rem_diff;
  logic                     q_bit;
  logic [CNT_W-1:0]         rem_nxt;
  logic [SUM_W-1:0]         dvd_nxt;
  logic [SUM_W-1:0]         quot;
  logic [SUM_W-1:0]         mono_c;
  logic                     phase_ge_one;
  logic signed [SUM_W:0]    diff_c;
  logic signed [FRAC:0]     frac_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_sh;
  logic [SB-1:0]            interp_c;
  logic [PH_W:0]            phase_sum;
  logic                     sum_ge_one;
  logic [PH_W-1:0]          phase_wrap;
  logic                     last_c;
  logic                     out_free;
  logic                     load_out;

  assign e_sum  = pop_data[STEP_W + CNT_W +: SUM_W];
  assign e_cnt  = pop_data[STEP_W +: CNT_W];
  assign e_step = pop_data[STEP_W-1:0];
  assign e_mag  = e_sum[SUM_W-1] ? (~e_sum + 1'b1) : e_sum;

  // restoring division of the frame magnitude by the channel count
  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt  = q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign dvd_nxt  = {dvd_r[SUM_W-2:0], q_bit};
  // keep the full quotient: a frame shrunk mid-way can average above full scale
  assign quot     = dvd_nxt;
  assign mono_c   = neg_r ? (~quot + 1'b1) : quot;

  assign phase_ge_one = |phase_r[PH_W-1:FRAC];
  assign diff_c   = $signed({mono_r[SUM_W-1], mono_r}) - $signed({prev_r[SUM_W-1], prev_r});
  assign frac_c   = $signed({1'b0, phase_r[FRAC-1:0]});
  assign prod_c   = diff_c * frac_c;
  assign prod_sh  = prod_r >>> FRAC;
  assign interp_c = prev_r[SB-1:0] + prod_sh[SB-1:0];

  assign phase_sum  = {1'b0, phase_r} + {1'b0, step_r};
  assign sum_ge_one = |phase_sum[PH_W:FRAC];
  assign phase_wrap = sum_ge_one ? PH_W'(phase_sum - ONE_X) : '0;
  assign last_c     = sum_ge_one || (nres_r == NRES_W'(pdlr_pkg::MAX_RESULTS - 1));

  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = (state_r == ST_OUT) && out_free;
  assign pop_ready = (state_r == ST_IDLE);

  assign out_valid       = out_valid_r;
  assign out_mono_sample = out_mono_r;
  assign out_last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            neg_r     <= e_sum[SUM_W-1];
            dvd_r     <= e_mag;
            rem_r     <= '0;
            dvs_r     <= e_cnt;
            step_r    <= e_step;
            bit_cnt_r <= BIT_W'(SUM_W - 1);
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r     <= rem_nxt;
          dvd_r     <= dvd_nxt;
          bit_cnt_r <= bit_cnt_r - 1'b1;
          if (bit_cnt_r == '0) begin
            if (!have_prev_r) begin
              // first frame only primes the history
              prev_r      <= mono_c;
              have_prev_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else if (phase_ge_one) begin
              phase_r <= phase_r - pdlr_pkg::PHASE_ONE;
              prev_r  <= mono_c;
              state_r <= ST_IDLE;
            end else begin
              mono_r  <= mono_c;
              nres_r  <= '0;
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= prod_c;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_mono_r  <= interp_c;
            out_last_r  <= last_c;
            out_valid_r <= 1'b1;
            nres_r      <= nres_r + 1'b1;
            if (last_c) begin
              phase_r <= phase_wrap;
              prev_r  <= mono_r;
              state_r <= ST_IDLE;
            end else begin
              phase_r <= phase_sum[PH_W-1:0];
              state_r <= ST_MUL;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `PDLR_ASSERT(a_mul_phase_below_one, ((state_r != ST_MUL) || !phase_ge_one), "phase at one")
  `PDLR_ASSERT_NEXT(a_last_ends_run, (load_out && last_c), (state_r == ST_IDLE), "run not ended")
  `PDLR_ASSERT(a_out_from_emit, (!$rose(out_valid_r) || ($past(state_r) == ST_OUT)), "bad rise")

endmodule

[test/tb_pcm_downmix_linear_resampler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_downmix_linear_resampler_unit
// Drives raw channel samples in every format through the downmix resampler.
// A behavioural copy of the averaging and interpolation predicts each mono
// output, and every returned output is compared in order against it. Both
// channels idle at random, and one phase holds the output back long enough
// to stall the input.
// ----------------------------------------------------------------------------
module tb_pcm_downmix_linear_resampler_unit;

  localparam int CHANNEL_LIMIT = 8;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [pdlr_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint Q_POS_LIM = (64'sd1 <<< (pdlr_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint Q_NEG_LIM = 64'sd1 <<< (pdlr_pkg::SAMPLE_BITS - 1);

  typedef struct {
    logic signed [pdlr_pkg::SAMPLE_BITS-1:0] mono_sample;
    logic                                    last_of_run;
  } mono_result_t;

  logic                                    clk;
  logic                                    rst_n         = 1'b0;
  logic                                    cfg_valid     = 1'b0;
  logic                                    cfg_ready;
  logic [pdlr_pkg::REG_IDX_W-1:0]          cfg_index     = '0;
  logic [pdlr_pkg::STEP_W-1:0]             cfg_data      = '0;
  logic                                    in_valid      = 1'b0;
  logic                                    in_ready;
  logic [pdlr_pkg::RAW_W-1:0]              in_raw_sample = '0;
  logic                                    out_valid;
  logic                                    out_ready     = 1'b0;
  logic signed [pdlr_pkg::SAMPLE_BITS-1:0] out_mono_sample;
  logic                                    out_last_of_run;

  // Predictor copy of the registers and the running state
  pdlr_pkg::fmt_t                  cur_fmt   = pdlr_pkg::CFG_RESET.sample_format;
  logic [pdlr_pkg::CHAN_CFG_W-1:0] cur_count = pdlr_pkg::CFG_RESET.channel_count;
  logic [pdlr_pkg::STEP_W-1:0]     cur_step  = pdlr_pkg::CFG_RESET.phase_step;
  int unsigned                     frame_pos = 0;
  longint                          frame_sum = 0;
  longint                          prev_mono = 0;
  bit                              have_prev = 1'b0;
  longint                          phase_acc = 0;

  mono_result_t expected_mono_q[$];
  mono_result_t oldest_expected;

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;

  pcm_downmix_linear_resampler_unit #(
    .MAX_CHANNELS(CHANNEL_LIMIT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mono_sample(out_mono_sample),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Float32 to Q1.23: truncate toward zero, saturate, NaN to zero
  function automatic longint q23_from_float(input logic [31:0] bits);
    bit                neg;
    int                ex;
    int                sh;
    longint unsigned   mant;
    longint unsigned   mag;
    neg  = bits[31];
    ex   = int'(bits[30:23]);
    mant = longint'(bits[22:0]);
    if (ex == 255) begin
      if (mant != 0) return 0;
      return neg ? -Q_NEG_LIM : Q_POS_LIM;
    end
    if (ex == 0) ex = 1;
    else mant |= 64'h80_0000;
    sh = ex - 151 + pdlr_pkg::SAMPLE_BITS;
    if (sh >= 40) mag = Q_NEG_LIM + 1;
    else if (sh >= 0) mag = mant << sh;
    else if (-sh >= 32) mag = 0;
    else mag = mant >> (-sh);
    if (neg) begin
      if (mag > Q_NEG_LIM) mag = Q_NEG_LIM;
      return -longint'(mag);
    end
    if (mag > Q_POS_LIM) mag = Q_POS_LIM;
    return longint'(mag);
  endfunction

  function automatic longint q23_from_raw(input pdlr_pkg::fmt_t fmt,
                                          input logic [pdlr_pkg::RAW_W-1:0] raw);
    case (fmt)
      pdlr_pkg::FMT_INT16: return longint'($signed(raw[15:0])) * 256;
      pdlr_pkg::FMT_INT24: return longint'($signed(raw[23:0]));
      pdlr_pkg::FMT_INT32: return longint'($signed(raw)) >>> 8;
      default:             return q23_from_float(raw);
    endcase
  endfunction

  // Accumulate one channel; on a closed frame queue the interpolated outputs
  task automatic downmix_and_interpolate(input logic [pdlr_pkg::RAW_W-1:0] raw);
    int unsigned  n_ch;
    longint       step;
    longint       mono;
    longint       diff;
    longint       interp;
    int           n;
    mono_result_t res;
    n_ch = (cur_count == 0) ? 1 :
           (cur_count > CHANNEL_LIMIT) ? CHANNEL_LIMIT : cur_count;
    step = (cur_step < pdlr_pkg::STEP_MIN) ? longint'(pdlr_pkg::STEP_MIN) :
           longint'(cur_step);
    frame_sum += q23_from_raw(cur_fmt, raw);
    frame_pos++;
    if (frame_pos < n_ch) return;
    mono      = frame_sum / longint'(n_ch);
    frame_pos = 0;
    frame_sum = 0;
    if (!have_prev) begin
      prev_mono = mono;
      have_prev = 1'b1;
      return;
    end
    n = 0;
    while (phase_acc < longint'(pdlr_pkg::PHASE_ONE) && n < pdlr_pkg::MAX_RESULTS) begin
      diff   = mono - prev_mono;
      interp = prev_mono + ((diff * phase_acc) >>> pdlr_pkg::PHASE_FRAC_BITS);
      res.mono_sample = interp[pdlr_pkg::SAMPLE_BITS-1:0];
      res.last_of_run = 1'b0;
      expected_mono_q.insert(expected_mono_q.size(), res);
      n++;
      phase_acc += step;
    end
    if (n > 0) expected_mono_q[expected_mono_q.size()-1].last_of_run = 1'b1;
    phase_acc = (phase_acc >= longint'(pdlr_pkg::PHASE_ONE)) ?
                phase_acc - longint'(pdlr_pkg::PHASE_ONE) : 0;
    prev_mono = mono;
  endtask

  // Track accepted requests on all three channels and check each output
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_mono_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected output: mono %0d last %0b", out_mono_sample, out_last_of_run);
        end else begin
          oldest_expected = expected_mono_q.pop_front();
          if (out_mono_sample !== oldest_expected.mono_sample ||
              out_last_of_run !== oldest_expected.last_of_run) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("mismatch: mono exp %0d got %0d, last exp %0b got %0b",
                       oldest_expected.mono_sample, out_mono_sample,
                       oldest_expected.last_of_run, out_last_of_run);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdlr_pkg::REG_SAMPLE_FORMAT: cur_fmt   = pdlr_pkg::fmt_t'(cfg_data[1:0]);
          pdlr_pkg::REG_CHANNEL_COUNT: cur_count = cfg_data[pdlr_pkg::CHAN_CFG_W-1:0];
          pdlr_pkg::REG_PHASE_STEP:    cur_step  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) downmix_and_interpolate(in_raw_sample);
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_raw_sample(input logic [pdlr_pkg::RAW_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_register(input logic [pdlr_pkg::REG_IDX_W-1:0] idx,
                                input logic [pdlr_pkg::STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every expected output, then idle so that the divider can clear
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mono_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input pdlr_pkg::fmt_t fmt,
                           input logic [pdlr_pkg::CHAN_CFG_W-1:0] count,
                           input logic [pdlr_pkg::STEP_W-1:0] step);
    wait_idle();
    write_register(pdlr_pkg::REG_SAMPLE_FORMAT, {22'($urandom), fmt});
    write_register(pdlr_pkg::REG_CHANNEL_COUNT, {20'($urandom), count});
    write_register(pdlr_pkg::REG_PHASE_STEP, step);
  endtask

  // Floats mostly of magnitude 2^-27 up to below 4, the rest raw noise
  function automatic logic [pdlr_pkg::RAW_W-1:0] random_raw(input pdlr_pkg::fmt_t fmt);
    if (fmt == pdlr_pkg::FMT_FLOAT32 && $urandom_range(3) != 0)
      return {1'($urandom_range(1)), 8'($urandom_range(100, 128)), 23'($urandom)};
    return $urandom;
  endfunction

  task automatic run_phase(input pdlr_pkg::fmt_t fmt,
                           input logic [pdlr_pkg::CHAN_CFG_W-1:0] count,
                           input logic [pdlr_pkg::STEP_W-1:0] step, input int items);
    configure(fmt, count, step);
    repeat (items) send_raw_sample(random_raw(fmt));
  endtask

  task automatic test_reset_defaults();
    // float32, two channels, step of three
    send_raw_sample(32'h3F00_0000);
    send_raw_sample(32'hBF00_0000);
    send_raw_sample(32'h3E80_0000);
    send_raw_sample(32'h3F40_0000);
  endtask

  task automatic test_float_specials();
    // step below the floor: eight outputs per frame
    configure(pdlr_pkg::FMT_FLOAT32, 4'd1, 24'd1);
    send_raw_sample(32'h7F80_0000);
    send_raw_sample(32'hFF80_0000);
    send_raw_sample(32'h7FC0_0000);
    send_raw_sample(32'h0000_0001);
    send_raw_sample(32'h3F80_0000);
    send_raw_sample(32'hBF80_0000);
    send_raw_sample(32'h7F7F_FFFF);
    send_raw_sample(32'h3F00_0000);
    send_raw_sample(32'h8000_0000);
  endtask

  task automatic test_integer_formats();
    // junk in the high bits must be ignored for the narrow formats
    configure(pdlr_pkg::FMT_INT16, 4'd1, 24'h01_0000);
    write_register(REG_UNUSED, 24'($urandom));
    send_raw_sample(32'h1234_7FFF);
    send_raw_sample(32'hFFFF_8000);
    configure(pdlr_pkg::FMT_INT24, 4'd1, 24'h01_0000);
    send_raw_sample(32'hA57F_FFFF);
    send_raw_sample(32'h0080_0000);
    configure(pdlr_pkg::FMT_INT32, 4'd1, 24'h01_0000);
    send_raw_sample(32'h7FFF_FFFF);
    send_raw_sample(32'h8000_0000);
    send_raw_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_count_change_mid_frame();
    // three of four channels in, then shrink the frame to two
    configure(pdlr_pkg::FMT_INT16, 4'd4, 24'h00_8000);
    repeat (3) send_raw_sample($urandom);
    configure(pdlr_pkg::FMT_INT16, 4'd2, 24'h00_8000);
    send_raw_sample($urandom);
  endtask

  task automatic test_config_extremes();
    run_phase(pdlr_pkg::FMT_INT16, 4'd0, pdlr_pkg::STEP_MIN, 24);
    run_phase(pdlr_pkg::FMT_INT24, 4'd15, 24'hFF_FFFF, 24);
    run_phase(pdlr_pkg::FMT_INT32, 4'd8, 24'h00_2000, 24);
  endtask

  task automatic test_random_phases(input int phases, input int items);
    int                              pick;
    logic [pdlr_pkg::CHAN_CFG_W-1:0] count;
    logic [pdlr_pkg::STEP_W-1:0]     step;
    for (int p = 0; p < phases; p++) begin
      pick  = $urandom_range(9);
      count = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 :
              4'($urandom_range(1, CHANNEL_LIMIT));
      pick  = $urandom_range(9);
      step  = (pick == 0) ? 24'($urandom_range(0, pdlr_pkg::STEP_MIN - 1)) :
              (pick == 1) ? 24'($urandom) : 24'($urandom_range(24'h00_2000, 24'h03_0000));
      run_phase(pdlr_pkg::fmt_t'($urandom_range(3)), count, step, items);
    end
  endtask

  task automatic test_output_backpressure();
    configure(pdlr_pkg::FMT_INT24, 4'd1, 24'h00_4000);
    // hold the output while the sender keeps pushing requests
    hold_off_left = 600;
    send_idle_pct = 0;
    repeat (40) send_raw_sample($urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 47;
    test_reset_defaults();
    test_float_specials();
    test_integer_formats();
    test_count_change_mid_frame();
    test_config_extremes();
    test_random_phases(4, 40);

    send_idle_pct = 47;
    recv_idle_pct = 36;
    test_random_phases(4, 40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_phases(2, 24);

    wait_idle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/pdlr_pkg.sv
hdl/pdlr_queue.sv
hdl/pdlr_front.sv
hdl/pdlr_back.sv
hdl/pcm_downmix_linear_resampler_unit.sv
test/tb_pcm_downmix_linear_resampler_unit.sv
